// ===== rtl/core/dsc_pkg.sv =====
// Shared types for the disjoint-set connectivity core: operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

  typedef enum logic [1:0] {
    OP_CONNECT = 2'd0,
    OP_QUERY   = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_SWEEP,
    S_WALK_A,
    S_COMP_A,
    S_START_B,
    S_WALK_B,
    S_COMP_B,
    S_DECIDE,
    S_JOIN_ROOT,
    S_JOIN_LINK,
    S_REPLY
  } state_t;

  // Where the next table read address (and the cursor) comes from.
  typedef enum logic [1:0] {
    SRC_NODE_A,
    SRC_NODE_B,
    SRC_LINK
  } step_src_t;

  // What the table write port stores.
  typedef enum logic [1:0] {
    WR_COMP,
    WR_JOIN_ROOT,
    WR_JOIN_LINK,
    WR_SWEEP
  } wr_src_t;

  typedef struct packed {
    logic      capture;
    logic      rd_en;
    logic      cur_ld;
    step_src_t src;
    logic      root_ld;
    logic      va_ld;
    logic      vb_ld;
    logic      ra_ld;
    logic      wr_en;
    wr_src_t   wr_src;
    logic      sweep_start;
    logic      sweep_step;
    logic      count_clear;
    logic      count_query;
    logic      same_ld;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic rd_root;
    logic rd_at_root;
    logic a_at_cur;
    logic b_at_cur;
    logic same;
    logic sweep_last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dsc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsc_ctrl.sv =====
// Controller state machine for the disjoint-set core: sequences find walks,
// path compression, linking, clear sweeps and the reply. Uses dsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dsc_pkg::stat_t stat,
  output dsc_pkg::cmd_t  cmd
);
  import dsc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (stat.op == OP_CLEAR) begin
          state_next = S_SWEEP;
        end else if ((stat.op == OP_CONNECT || stat.op == OP_QUERY) && stat.in_range) begin
          state_next = S_WALK_A;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_SWEEP: begin
        if (stat.sweep_last) state_next = S_REPLY;
      end
      S_WALK_A: begin
        if (stat.rd_root) state_next = stat.a_at_cur ? S_START_B : S_COMP_A;
      end
      S_COMP_A: begin
        if (stat.rd_at_root) state_next = S_START_B;
      end
      S_START_B: state_next = S_WALK_B;
      S_WALK_B: begin
        if (stat.rd_root) state_next = stat.b_at_cur ? S_DECIDE : S_COMP_B;
      end
      S_COMP_B: begin
        if (stat.rd_at_root) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.op == OP_CONNECT && !stat.same) state_next = S_JOIN_ROOT;
        else state_next = S_REPLY;
      end
      S_JOIN_ROOT: state_next = S_JOIN_LINK;
      S_JOIN_LINK: state_next = S_REPLY;
      S_REPLY: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.src  = SRC_LINK;
    in_ready = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_src     = WR_SWEEP;
        cmd.sweep_step = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        priority if (stat.op == OP_CLEAR) begin
          cmd.sweep_start = 1'b1;
          cmd.count_clear = 1'b1;
        end else if ((stat.op == OP_CONNECT || stat.op == OP_QUERY) && stat.in_range) begin
          cmd.rd_en  = 1'b1;
          cmd.cur_ld = 1'b1;
          cmd.src    = SRC_NODE_A;
        end else begin
          cmd.rd_en = 1'b0;
        end
      end
      S_SWEEP: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_src     = WR_SWEEP;
        cmd.sweep_step = 1'b1;
      end
      S_WALK_A, S_WALK_B: begin
        if (stat.rd_root) begin
          cmd.root_ld = 1'b1;
          cmd.va_ld   = (state == S_WALK_A);
          cmd.vb_ld   = (state == S_WALK_B);
          // Restart from the start node to compress the path just walked.
          if (state == S_WALK_A && !stat.a_at_cur) begin
            cmd.rd_en  = 1'b1;
            cmd.cur_ld = 1'b1;
            cmd.src    = SRC_NODE_A;
          end
          if (state == S_WALK_B && !stat.b_at_cur) begin
            cmd.rd_en  = 1'b1;
            cmd.cur_ld = 1'b1;
            cmd.src    = SRC_NODE_B;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.cur_ld = 1'b1;
          cmd.src    = SRC_LINK;
        end
      end
      S_COMP_A, S_COMP_B: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_COMP;
        cmd.cur_ld = 1'b1;
        cmd.src    = SRC_LINK;
        cmd.rd_en  = !stat.rd_at_root;
      end
      S_START_B: begin
        cmd.ra_ld  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.cur_ld = 1'b1;
        cmd.src    = SRC_NODE_B;
      end
      S_DECIDE: begin
        cmd.same_ld     = 1'b1;
        cmd.count_query = (stat.op == OP_QUERY);
      end
      S_JOIN_ROOT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_JOIN_ROOT;
      end
      S_JOIN_LINK: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_JOIN_LINK;
      end
      S_REPLY: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsc_datapath.sv =====
// Datapath for the disjoint-set core: link table RAM, walk cursor, roots,
// set sizes, counters, sweep counter and output register. Uses dsc_pkg, dsc_ram.
`timescale 1ns / 1ps
`default_nettype none

module dsc_datapath #(
  parameter int MAX_NODES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [10:0]    cfg_data,
  input  logic [1:0]     operation,
  input  logic [9:0]     node_a,
  input  logic [9:0]     node_b,
  input  dsc_pkg::cmd_t  cmd,
  output dsc_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           same_set,
  output logic [31:0]    yes_total,
  output logic [31:0]    no_total
);
  import dsc_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int EW = IW + 1;
  localparam logic [IW-1:0]        LAST_NODE  = IW'(MAX_NODES - 1);
  localparam logic signed [EW:0]   SIZE_FLOOR = (EW + 1)'(-MAX_NODES);
  localparam logic [31:0]          COUNT_MAX  = '1;

  logic [10:0]          node_count;
  op_t                  op_q;
  logic [9:0]           node_a_q;
  logic [9:0]           node_b_q;
  logic [IW-1:0]        cur;
  logic [IW-1:0]        root;
  logic [IW-1:0]        ra;
  logic signed [EW-1:0] va;
  logic signed [EW-1:0] vb;
  logic                 same_q;
  logic [IW-1:0]        sweep_idx;
  logic [IW-1:0]        sweep_last;
  logic [31:0]          yes_count;
  logic [31:0]          no_count;

  logic [31:0]          lim;
  logic [IW-1:0]        node_a_idx;
  logic [IW-1:0]        node_b_idx;
  logic [IW-1:0]        link_idx;
  logic [IW-1:0]        step_addr;
  logic                 mem_wr_en;
  logic [IW-1:0]        mem_wr_addr;
  logic [EW-1:0]        mem_wr_data;
  logic [EW-1:0]        mem_rd_data;
  logic signed [EW:0]   size_sum;
  logic signed [EW:0]   size_sat;
  logic                 a_wins;

  // Effective node count: zero counts as one, clamp at the table depth.
  always_comb begin
    if (node_count == 11'd0) begin
      lim = 32'd1;
    end else if (32'(node_count) > 32'(MAX_NODES)) begin
      lim = 32'(MAX_NODES);
    end else begin
      lim = 32'(node_count);
    end
  end

  assign node_a_idx = IW'(node_a_q);
  assign node_b_idx = IW'(node_b_q);
  assign link_idx   = mem_rd_data[IW-1:0];

  always_comb begin
    unique case (cmd.src)
      SRC_NODE_A: step_addr = node_a_idx;
      SRC_NODE_B: step_addr = node_b_idx;
      SRC_LINK:   step_addr = link_idx;
      default:    step_addr = link_idx;
    endcase
  end

  // Union by size: the root with the more negative entry is the larger set.
  assign size_sum = {va[EW-1], va} + {vb[EW-1], vb};
  assign size_sat = (size_sum < SIZE_FLOOR) ? SIZE_FLOOR : size_sum;
  assign a_wins   = !(va > vb);

  always_comb begin
    mem_wr_en = cmd.wr_en;
    unique case (cmd.wr_src)
      WR_COMP: begin
        mem_wr_addr = cur;
        mem_wr_data = {1'b0, root};
      end
      WR_JOIN_ROOT: begin
        mem_wr_addr = a_wins ? ra : root;
        mem_wr_data = size_sat[EW-1:0];
      end
      WR_JOIN_LINK: begin
        mem_wr_addr = a_wins ? root : ra;
        mem_wr_data = {1'b0, (a_wins ? ra : root)};
      end
      WR_SWEEP: begin
        mem_wr_addr = sweep_idx;
        mem_wr_data = '1;
      end
    endcase
  end

  dsc_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_NODES)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(step_addr),
    .rd_data(mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 11'd1024;
    end else if (cfg_write) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op_t'(operation);
      node_a_q <= node_a;
      node_b_q <= node_b;
    end
    if (cmd.cur_ld)  cur  <= step_addr;
    if (cmd.root_ld) root <= cur;
    if (cmd.ra_ld)   ra   <= root;
    if (cmd.va_ld)   va   <= mem_rd_data;
    if (cmd.vb_ld)   vb   <= mem_rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      same_q <= 1'b0;
    end else if (cmd.capture) begin
      same_q <= 1'b0;
    end else if (cmd.same_ld) begin
      same_q <= (ra == root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx  <= '0;
      sweep_last <= LAST_NODE;
    end else if (cmd.sweep_start) begin
      sweep_idx  <= '0;
      sweep_last <= IW'(lim - 32'd1);
    end else if (cmd.sweep_step) begin
      sweep_idx  <= sweep_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.count_clear) begin
      yes_count <= '0;
      no_count  <= '0;
    end else if (cmd.count_query) begin
      if (ra == root) begin
        if (yes_count != COUNT_MAX) yes_count <= yes_count + 32'd1;
      end else begin
        if (no_count != COUNT_MAX) no_count <= no_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      same_set  <= same_q;
      yes_total <= yes_count;
      no_total  <= no_count;
    end
  end

  always_comb begin
    stat.op         = op_q;
    stat.in_range   = (32'(node_a_q) < lim) && (32'(node_b_q) < lim);
    stat.rd_root    = mem_rd_data[EW-1];
    stat.rd_at_root = (link_idx == root);
    stat.a_at_cur   = (node_a_idx == cur);
    stat.b_at_cur   = (node_b_idx == cur);
    stat.same       = (ra == root);
    stat.sweep_last = (sweep_idx == sweep_last);
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/core/disjoint_set_connectivity_core.sv =====
// Top level of the disjoint-set connectivity core: controller plus datapath.
// Depends on dsc_pkg, dsc_ctrl, dsc_datapath (and dsc_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Union-find engine over nodes below the effective node count (node_count,
// with zero taken as one and clamped at MAX_NODES), with union by size and
// path compression, one request at a time. The link table lives in a single
// RAM with one read and one write port, and each parent hop waits on the
// previous read because the next read address comes from the previous read
// data. A connect or query request walks each parent hop from node_a and
// node_b to their roots once to find the root and once to rewrite it, and a
// connect that links two sets then writes the new root size and the link.
// With compression the hop counts stay small. A clear request sweeps the
// table one entry per cycle. Every request also waits in its reply step for
// as long as the previous response still sits untaken in the output register.
// After reset, a clearing pass over all MAX_NODES entries initializes the
// table and in_ready stays low until it ends; node_count writes are taken at
// any time, but change it only while the core is idle.
// Requests with an index at or above the effective node count, or the unused
// operation code, give a response with same_set low and the counters
// untouched. A response waiting in the output register does not block the
// next request from being accepted.
module disjoint_set_connectivity_core #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [9:0]  node_a,
  input  logic [9:0]  node_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        same_set,
  output logic [31:0] yes_total,
  output logic [31:0] no_total
);
  import dsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request: find A, compress A, find B, compress B, link, reply (a clear sweeps the table instead).
  dsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Hold the table, cursor, roots, sizes, counters and the response register.
  dsc_datapath #(
    .MAX_NODES(MAX_NODES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .operation(operation),
    .node_a   (node_a),
    .node_b   (node_b),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .same_set (same_set),
    .yes_total(yes_total),
    .no_total (no_total)
  );

  // A request is never accepted while the table is being written.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !cmd.wr_en)
    else $error("table write during request acceptance");

  // Only one request in flight: ready drops right after acceptance.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while busy");

  // The response register is loaded only when it is free or being drained.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("response overwritten before it was taken");

  // A response appears only as the result of a load by the controller.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("response valid without a load");

endmodule

`default_nettype wire
